// ===== rtl/core/bmss_pkg.sv =====
`default_nettype none

package bmss_pkg;

   // averaging and stall trip
   localparam int unsigned AVG_SAMPLES = 8;
   localparam int unsigned STALL_TRIP  = 200;

   // field widths
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned BATT_W    = 16;
   localparam int unsigned ADC_W     = 12;
   localparam int unsigned DUTY_W    = 7;
   localparam int unsigned CUR_W     = 15;
   localparam int unsigned TARGET_W  = 24;
   localparam int unsigned SCALE_W   = 16;
   localparam int unsigned CNT_W     = 8;
   localparam int unsigned SUM_W     = $clog2(AVG_SAMPLES * (2 ** ADC_W));
   localparam int unsigned LEFT_W    = $clog2(AVG_SAMPLES + 1);
   localparam int unsigned PROD_W    = ADC_W + SCALE_W;
   localparam int unsigned DIV_BITS  = TARGET_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

   // configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = TARGET_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_VOLT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADC_BASELINE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOLOAD_THR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLOAD_THR  = 3'd5;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_RAMP   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STALL  = 2'd2;

   // numeric limits
   localparam logic [DUTY_W-1:0] DUTY_MAX        = 7'd100;
   localparam logic [DUTY_W-1:0] NOLOAD_DUTY_MIN = 7'd10;
   localparam logic [CUR_W-1:0]  CURRENT_MAX     = 15'd32767;
   localparam logic [CNT_W-1:0]  CNT_MAX         = 8'd255;
   localparam logic [CNT_W-1:0]  STALL_TRIP_CNT  = CNT_W'(STALL_TRIP);
   localparam logic [LEFT_W-1:0] LEFT_RELOAD     = LEFT_W'(AVG_SAMPLES);

   localparam logic [SCALE_W-1:0] SCALE_RESET    = 16'd256;
   localparam logic [CUR_W-1:0]   OVERLOAD_RESET = 15'd32767;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic ramp_apply;
      logic sum_step;
      logic mul_step;
      logic scale_step;
      logic stall_step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic avg_due;
   } dp_status_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target_voltage;
      logic [ADC_W-1:0]    adc_baseline;
      logic [SCALE_W-1:0]  current_scale;
      logic [CUR_W-1:0]    noload_threshold;
      logic [CUR_W-1:0]    overload_threshold;
   } dp_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/bmss_ctrl.sv =====
`default_nettype none

module bmss_ctrl
   import bmss_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [KIND_W-1:0]   req_kind,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic                ramp_enable,
   input  wire dp_status_type       status,
   output dp_cmd_type               cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RAMP,
      ST_SUM,
      ST_MUL,
      ST_SCALE,
      ST_STALL,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               div_cnt_in  = '0;
               case (req_kind)
                  KIND_RAMP:   state_in = ramp_enable ? ST_DIV : ST_FINISH;
                  KIND_SAMPLE: state_in = ST_SUM;
                  KIND_STALL:  state_in = ST_STALL;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            cmd.ramp_apply = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            state_in     = status.avg_due ? ST_MUL : ST_FINISH;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_step = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_STALL: begin
            cmd.stall_step = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_div_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_cnt_ff <= DIV_CNT_W'(DIV_BITS - 1))
      else $error("divider step count out of range");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item taken while another is in flight");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result loaded over an untaken result");

   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("finished item not presented");

endmodule

`default_nettype wire

// ===== rtl/core/bmss_dpath.sv =====
`default_nettype none

module bmss_dpath
   import bmss_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status,
   input  wire dp_cfg_type          cfg,
   input  wire logic [BATT_W-1:0]   req_battery_voltage,
   input  wire logic [ADC_W-1:0]    req_adc_sample,
   output logic [DUTY_W-1:0]        rsp_pwm_duty,
   output logic [CUR_W-1:0]         rsp_brush_current,
   output logic                     rsp_current_updated,
   output logic                     rsp_stall_detected
);

   // item registers
   logic [BATT_W-1:0]   battery_ff;
   logic [ADC_W-1:0]    sample_ff;

   // serial divider
   logic [BATT_W-1:0]   rem_ff, rem_in;
   logic [TARGET_W-1:0] quo_ff, quo_in;
   logic [BATT_W:0]     rem_shift;
   logic                rem_ge;

   // motor state
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [CUR_W-1:0]    current_ff, current_in;
   logic [CNT_W-1:0]    trip_count_ff, trip_count_in;
   logic [ADC_W-1:0]    diff_ff, diff_in;
   logic [PROD_W-1:0]   prod_ff;
   logic                updated_ff, updated_in;
   logic                stalled_ff, stalled_in;

   // output register
   logic [DUTY_W-1:0]   out_duty_ff;
   logic [CUR_W-1:0]    out_current_ff;
   logic                out_updated_ff;
   logic                out_stalled_ff;

   logic [DUTY_W-1:0]   target;
   logic [SUM_W-1:0]    sum_add;
   logic [ADC_W-1:0]    avg;
   logic [CNT_W:0]      cnt_wide;
   logic [CNT_W-1:0]    cnt_sat;

   function automatic logic cur_below_noload();
      return current_ff < cfg.noload_threshold;
   endfunction

   assign status.avg_due = (left_ff <= LEFT_W'(1));

   assign rem_shift = {rem_ff, quo_ff[TARGET_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, battery_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.capture) begin
         rem_in = '0;
         quo_in = cfg.target_voltage;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_in = BATT_W'(rem_shift - {1'b0, battery_ff});
         end else begin
            rem_in = rem_shift[BATT_W-1:0];
         end
         quo_in = {quo_ff[TARGET_W-2:0], rem_ge};
      end
   end

   // zero battery reads as full duty
   always_comb begin
      if (battery_ff == '0) begin
         target = DUTY_MAX;
      end else if (quo_ff > TARGET_W'(DUTY_MAX)) begin
         target = DUTY_MAX;
      end else begin
         target = quo_ff[DUTY_W-1:0];
      end
   end

   assign sum_add = sum_ff + SUM_W'(sample_ff);
   assign avg     = ADC_W'(sum_add / AVG_SAMPLES);

   always_comb begin
      if (cur_below_noload()) begin
         cnt_wide = {1'b0, trip_count_ff} + ((duty_ff > NOLOAD_DUTY_MIN) ? 9'd1 : 9'd0);
      end else if (current_ff > cfg.overload_threshold) begin
         cnt_wide = {1'b0, trip_count_ff} + 9'd4;
      end else begin
         cnt_wide = '0;
      end
      cnt_sat = cnt_wide[CNT_W] ? CNT_MAX : cnt_wide[CNT_W-1:0];
   end

   always_comb begin
      duty_in       = duty_ff;
      sum_in        = sum_ff;
      left_in       = left_ff;
      current_in    = current_ff;
      trip_count_in = trip_count_ff;
      diff_in       = diff_ff;
      updated_in    = updated_ff;
      stalled_in    = stalled_ff;
      if (cmd.capture) begin
         updated_in = 1'b0;
         stalled_in = 1'b0;
      end
      if (cmd.ramp_apply) begin
         if (target == '0) begin
            duty_in = '0;
         end else if (duty_ff < target) begin
            duty_in = duty_ff + 1'b1;
         end else if (duty_ff != '0) begin
            duty_in = duty_ff - 1'b1;
         end
      end
      if (cmd.sum_step) begin
         if (status.avg_due) begin
            sum_in     = '0;
            left_in    = LEFT_RELOAD;
            updated_in = 1'b1;
            diff_in    = (avg > cfg.adc_baseline) ? avg - cfg.adc_baseline : '0;
         end else begin
            sum_in  = sum_add;
            left_in = left_ff - 1'b1;
         end
      end
      if (cmd.scale_step) begin
         if (prod_ff[PROD_W-1:CUR_W+8] != '0) begin
            current_in = CURRENT_MAX;
         end else begin
            current_in = prod_ff[CUR_W+7:8];
         end
      end
      if (cmd.stall_step) begin
         if (cnt_sat > STALL_TRIP_CNT) begin
            trip_count_in = '0;
            stalled_in    = 1'b1;
         end else begin
            trip_count_in = cnt_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff       <= '0;
         sum_ff        <= '0;
         left_ff       <= LEFT_RELOAD;
         current_ff    <= '0;
         trip_count_ff <= '0;
      end else begin
         duty_ff       <= duty_in;
         sum_ff        <= sum_in;
         left_ff       <= left_in;
         current_ff    <= current_in;
         trip_count_ff <= trip_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         battery_ff <= req_battery_voltage;
         sample_ff  <= req_adc_sample;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      diff_ff    <= diff_in;
      updated_ff <= updated_in;
      stalled_ff <= stalled_in;
      if (cmd.mul_step) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'(cfg.current_scale);
      end
      if (cmd.load_out) begin
         out_duty_ff    <= duty_ff;
         out_current_ff <= current_ff;
         out_updated_ff <= updated_ff;
         out_stalled_ff <= stalled_ff;
      end
   end

   assign rsp_pwm_duty        = out_duty_ff;
   assign rsp_brush_current   = out_current_ff;
   assign rsp_current_updated = out_updated_ff;
   assign rsp_stall_detected  = out_stalled_ff;

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= DUTY_MAX)
      else $error("duty above full scale");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= LEFT_RELOAD && left_ff != '0)
      else $error("sample countdown out of range");

   a_trip_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.stall_step && cnt_sat > STALL_TRIP_CNT |=> trip_count_ff == '0 && stalled_ff)
      else $error("stall trip did not clear the counter");

endmodule

`default_nettype wire

// ===== rtl/core/brush_motor_softstart_stall_monitor_unit.sv =====
`default_nettype none

// Brush motor soft-start and stall monitor. Each item on req_ is a ramp tick,
// an ADC sample or a stall check, and gives exactly one result on rsp_ with the
// duty and brush current after that item. A ramp tick runs a restoring
// divider, one quotient bit per cycle over the 24-bit target voltage, and
// then applies the ramp step; a sample adds into the running sum and, when
// it completes an eight-sample average, also multiplies by the scale and
// then saturates; a stall check updates the trip counter; an unused kind or
// a tick with ramping off goes straight to the result. One item is worked at
// a time; the next item is taken the cycle after a result is loaded into the
// output register, even if that result is not yet taken. Configuration writes
// are always accepted and should be made while no item is in flight.
module brush_motor_softstart_stall_monitor_unit
   import bmss_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [KIND_W-1:0]      req_kind,
   input  wire logic [BATT_W-1:0]      req_battery_voltage,
   input  wire logic [ADC_W-1:0]       req_adc_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [DUTY_W-1:0]           rsp_pwm_duty,
   output logic [CUR_W-1:0]            rsp_brush_current,
   output logic                        rsp_current_updated,
   output logic                        rsp_stall_detected,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic          ramp_enable_ff;
   dp_cfg_type    cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_enable_ff            <= 1'b0;
         cfg_ff.target_voltage     <= '0;
         cfg_ff.adc_baseline       <= '0;
         cfg_ff.current_scale      <= SCALE_RESET;
         cfg_ff.noload_threshold   <= '0;
         cfg_ff.overload_threshold <= OVERLOAD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RAMP_ENABLE:   ramp_enable_ff            <= csr_data[0];
            CSR_TARGET_VOLT:   cfg_ff.target_voltage     <= csr_data[TARGET_W-1:0];
            CSR_ADC_BASELINE:  cfg_ff.adc_baseline       <= csr_data[ADC_W-1:0];
            CSR_CURRENT_SCALE: cfg_ff.current_scale      <= csr_data[SCALE_W-1:0];
            CSR_NOLOAD_THR:    cfg_ff.noload_threshold   <= csr_data[CUR_W-1:0];
            CSR_OVERLOAD_THR:  cfg_ff.overload_threshold <= csr_data[CUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bmss_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ramp_enable (ramp_enable_ff),
      .status      (status),
      .cmd         (cmd)
   );

   bmss_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cfg                 (cfg_ff),
      .req_battery_voltage (req_battery_voltage),
      .req_adc_sample      (req_adc_sample),
      .rsp_pwm_duty        (rsp_pwm_duty),
      .rsp_brush_current   (rsp_brush_current),
      .rsp_current_updated (rsp_current_updated),
      .rsp_stall_detected  (rsp_stall_detected)
   );

endmodule

`default_nettype wire

// ===== sim/brush_motor_softstart_stall_monitor_checker.sv =====
`timescale 1ns / 100ps

module brush_motor_softstart_stall_monitor_checker
   import bmss_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [BATT_W-1:0]     req_battery_voltage,
   input  wire logic [ADC_W-1:0]      req_adc_sample,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [DUTY_W-1:0]     rsp_pwm_duty,
   input  wire logic [CUR_W-1:0]      rsp_brush_current,
   input  wire logic                  rsp_current_updated,
   input  wire logic                  rsp_stall_detected,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [CUR_W-1:0]  current;
      logic              updated;
      logic              stalled;
   } motor_status_type;

   // register copies
   logic                ramp_on;
   logic [TARGET_W-1:0] target_volt;
   logic [ADC_W-1:0]    baseline;
   logic [SCALE_W-1:0]  scale;
   logic [CUR_W-1:0]    noload_thr;
   logic [CUR_W-1:0]    overload_thr;

   // monitor state
   logic [DUTY_W-1:0]   duty;
   logic [SUM_W-1:0]    sum;
   logic [LEFT_W-1:0]   left;
   logic [CUR_W-1:0]    current;
   logic [CNT_W-1:0]    trip_count;

   motor_status_type status_due_q[$];
   int errors = 0;

   function automatic motor_status_type step_motor(input logic [KIND_W-1:0] kind,
                                                   input logic [BATT_W-1:0] batt,
                                                   input logic [ADC_W-1:0]  sample);
      motor_status_type res;
      logic [TARGET_W-1:0]  quot;
      logic [DUTY_W-1:0]    goal;
      logic [ADC_W-1:0]     avg;
      logic [ADC_W-1:0]     diff;
      logic [PROD_W-1:0]    prod;
      logic [PROD_W-9:0]    scaled;
      int unsigned          cnt;
      res = '0;
      case (kind)
         KIND_RAMP: begin
            if (ramp_on) begin
               if (batt == '0) begin
                  goal = DUTY_MAX;
               end else begin
                  quot = target_volt / TARGET_W'(batt);
                  goal = (quot > TARGET_W'(DUTY_MAX)) ? DUTY_MAX : quot[DUTY_W-1:0];
               end
               if (duty < goal) begin
                  duty = duty + 1'b1;
               end else if (duty != '0) begin
                  duty = duty - 1'b1;
               end
               if (goal == '0) duty = '0;
            end
         end
         KIND_SAMPLE: begin
            sum = sum + SUM_W'(sample);
            if (left != '0) left = left - 1'b1;
            if (left == '0) begin
               avg = ADC_W'(sum / AVG_SAMPLES);
               diff = (avg > baseline) ? avg - baseline : '0;
               prod = PROD_W'(diff) * PROD_W'(scale);
               scaled = prod[PROD_W-1:8];
               current = (scaled > CURRENT_MAX) ? CURRENT_MAX : scaled[CUR_W-1:0];
               sum = '0;
               left = LEFT_RELOAD;
               res.updated = 1'b1;
            end
         end
         KIND_STALL: begin
            cnt = trip_count;
            if (current < noload_thr) begin
               if (duty > NOLOAD_DUTY_MIN) cnt = cnt + 1;
            end else if (current > overload_thr) begin
               cnt = cnt + 4;
            end else begin
               cnt = 0;
            end
            if (cnt > CNT_MAX) cnt = CNT_MAX;
            if (cnt > STALL_TRIP) begin
               cnt = 0;
               res.stalled = 1'b1;
            end
            trip_count = CNT_W'(cnt);
         end
         default: begin
         end
      endcase
      res.duty = duty;
      res.current = current;
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      motor_status_type want;
      if (reset) begin
         ramp_on      = 1'b0;
         target_volt  = '0;
         baseline     = '0;
         scale        = SCALE_RESET;
         noload_thr   = '0;
         overload_thr = OVERLOAD_RESET;
         duty         = '0;
         sum          = '0;
         left         = LEFT_RELOAD;
         current      = '0;
         trip_count   = '0;
         status_due_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due_q.size() == 0) begin
               $display("%0t: result item with nothing expected, duty %0d current %0d",
                        $time, rsp_pwm_duty, rsp_brush_current);
               errors++;
            end else begin
               want = status_due_q.pop_front();
               check_field("pwm_duty", want.duty, rsp_pwm_duty);
               check_field("brush_current", want.current, rsp_brush_current);
               check_field("current_updated", want.updated, rsp_current_updated);
               check_field("stall_detected", want.stalled, rsp_stall_detected);
            end
         end
         if (req_valid && req_ready) begin
            status_due_q.push_back(step_motor(req_kind, req_battery_voltage,
                                              req_adc_sample));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RAMP_ENABLE:   ramp_on      = csr_data[0];
               CSR_TARGET_VOLT:   target_volt  = csr_data[TARGET_W-1:0];
               CSR_ADC_BASELINE:  baseline     = csr_data[ADC_W-1:0];
               CSR_CURRENT_SCALE: scale        = csr_data[SCALE_W-1:0];
               CSR_NOLOAD_THR:    noload_thr   = csr_data[CUR_W-1:0];
               CSR_OVERLOAD_THR:  overload_thr = csr_data[CUR_W-1:0];
               default: begin
               end
            endcase
         end
      end
      pending <= status_due_q.size();
      fail_count <= errors;
   end

endmodule

// ===== sim/brush_motor_softstart_stall_monitor_unit_tb.sv =====
`timescale 1ns / 100ps

module brush_motor_softstart_stall_monitor_unit_tb;
   import bmss_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 40;
   localparam int RAND_PHASES    = 6;

   localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind;
   logic [BATT_W-1:0]     req_battery_voltage;
   logic [ADC_W-1:0]      req_adc_sample;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [DUTY_W-1:0]     rsp_pwm_duty;
   logic [CUR_W-1:0]      rsp_brush_current;
   logic                  rsp_current_updated;
   logic                  rsp_stall_detected;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int fail_count;
   int pending;

   logic calm = 1'b0;
   logic hold_req = 1'b0;
   logic [TARGET_W-1:0] stim_target = '0;
   logic [ADC_W-1:0]    stim_baseline = '0;

   brush_motor_softstart_stall_monitor_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_battery_voltage (req_battery_voltage),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pwm_duty        (rsp_pwm_duty),
      .rsp_brush_current   (rsp_brush_current),
      .rsp_current_updated (rsp_current_updated),
      .rsp_stall_detected  (rsp_stall_detected),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   brush_motor_softstart_stall_monitor_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_battery_voltage (req_battery_voltage),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pwm_duty        (rsp_pwm_duty),
      .rsp_brush_current   (rsp_brush_current),
      .rsp_current_updated (rsp_current_updated),
      .rsp_stall_detected  (rsp_stall_detected),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // battery values aimed so that target / battery often lands inside 0..100
   function automatic logic [BATT_W-1:0] pick_battery();
      int unsigned r;
      int unsigned q;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 6) begin
         q = stim_target / $urandom_range(1, 110);
         if (q <= 32'hFFFF) return BATT_W'(q);
      end
      return BATT_W'($urandom);
   endfunction

   function automatic logic [ADC_W-1:0] pick_sample();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) begin
         v = int'(stim_baseline) + int'($urandom_range(0, 64)) - 32;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         return ADC_W'(v);
      end
      return ADC_W'($urandom_range(0, 4095));
   endfunction

   // valid stays high across back-to-back items, dropped only for a gap
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BATT_W-1:0] batt,
                            input logic [ADC_W-1:0] sample);
      int gap;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_battery_voltage <= batt;
      req_adc_sample <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input int ramp_pct, input int stall_pct);
      logic [KIND_W-1:0] kind;
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) kind = KIND_UNUSED;
      else if (r < 3 + ramp_pct) kind = KIND_RAMP;
      else if (r < 3 + ramp_pct + stall_pct) kind = KIND_STALL;
      else kind = KIND_SAMPLE;
      send_item(kind, pick_battery(), pick_sample());
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input int unsigned enable,
                           input int unsigned target,
                           input int unsigned base,
                           input int unsigned scale,
                           input int unsigned noload,
                           input int unsigned overload);
      stim_target = TARGET_W'(target);
      stim_baseline = ADC_W'(base);
      write_reg(CSR_RAMP_ENABLE, CSR_DATA_W'(enable));
      write_reg(CSR_TARGET_VOLT, CSR_DATA_W'(target));
      write_reg(CSR_ADC_BASELINE, CSR_DATA_W'(base));
      write_reg(CSR_CURRENT_SCALE, CSR_DATA_W'(scale));
      write_reg(CSR_NOLOAD_THR, CSR_DATA_W'(noload));
      write_reg(CSR_OVERLOAD_THR, CSR_DATA_W'(overload));
   endtask

   // stop offering items and wait for every result to come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int phase);
      int n_items;
      int ramp_pct;
      int stall_pct;
      n_items = 125;
      ramp_pct = 30;
      stall_pct = 35;
      case (phase)
         0: begin
            // no-load stalls: ramp the duty past the floor, then mostly checks
            set_regs(1, 32'hFFFFFF, 0, 32'(SCALE_RESET), 32'h7FFF, 32'(OVERLOAD_RESET));
            repeat (12) send_item(KIND_RAMP, '0, pick_sample());
            n_items = 260;
            ramp_pct = 5;
            stall_pct = 85;
         end
         1: begin
            // overload stalls
            set_regs(1, $urandom_range(0, 6553500), $urandom_range(0, 1024),
                     $urandom_range(256, 65535), 0, $urandom_range(0, 200));
            n_items = 250;
            ramp_pct = 25;
            stall_pct = 50;
         end
         2: begin
            calm <= 1'b1;
            set_regs(0, $urandom_range(0, 32'hFFFFFF), $urandom_range(0, 4095), 0,
                     $urandom_range(0, 32767), $urandom_range(0, 32767));
         end
         3: begin
            set_regs(1, $urandom_range(0, 6553500), 32'hFFF, 32'hFFFF,
                     $urandom_range(0, 32767), 32'h7FFF);
            hold_req <= 1'b1;
         end
         4: begin
            set_regs(1, 0, $urandom_range(0, 4095), $urandom_range(0, 65535),
                     $urandom_range(0, 32767), $urandom_range(0, 32767));
            write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom));
         end
         default: begin
            // full-width data, upper bits must be dropped per register
            set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      endcase
      repeat (n_items) send_random(ramp_pct, stall_pct);
      drain();
      calm <= 1'b0;
   endtask

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      int stall_left;
      bit held;
      stall_left = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= KIND_RAMP;
      req_battery_voltage <= '0;
      req_adc_sample <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_RAMP_ENABLE;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ramping off, so the duty holds
      send_item(KIND_RAMP, '0, '0);
      send_item(KIND_UNUSED, '1, '1);
      send_item(KIND_STALL, '0, '0);
      drain();

      // zero and full battery, full scale saturates the current
      set_regs(1, 32'hFFFFFF, 0, 32'hFFFF, 0, 0);
      send_item(KIND_RAMP, '0, '0);
      send_item(KIND_RAMP, '1, '0);
      send_item(KIND_RAMP, 16'd1, '0);
      repeat (8) send_item(KIND_SAMPLE, '0, '1);
      send_item(KIND_STALL, '0, '0);
      send_item(KIND_UNUSED, '0, '0);
      drain();

      // zero target forces the duty to zero, average below baseline clamps
      set_regs(1, 0, 32'hFFF, 32'hFFFF, 0, 0);
      send_item(KIND_RAMP, 16'h1234, '0);
      for (int i = 0; i < 8; i++) send_item(KIND_SAMPLE, '0, (i % 2 == 0) ? '0 : '1);
      drain();

      for (int p = 0; p < RAND_PHASES; p++) run_phase(p);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/bmss_pkg.sv
rtl/core/bmss_ctrl.sv
rtl/core/bmss_dpath.sv
rtl/core/brush_motor_softstart_stall_monitor_unit.sv
sim/brush_motor_softstart_stall_monitor_checker.sv
sim/brush_motor_softstart_stall_monitor_unit_tb.sv
